// ===== hdl/ulh_pkg.sv =====
// Package: shared types, codes and keyword tables for the serial-link handshake controller.
package ulh_pkg;

    // Line buffer limit and the saturation point of the line length
    localparam int MAX_LINE = 256;
    localparam int LINE_CAP = (MAX_LINE - 1 > 255) ? 255 : MAX_LINE - 1;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int TX_W      = 2;
    localparam int EV_W      = 3;
    localparam int STATE_W   = 2;
    localparam int LEN_W     = 8;
    localparam int IDLE_W    = 20;
    localparam int TIMEOUT_W = 20;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // Idle counter saturation value
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = TIMEOUT_W'(5000);
    localparam logic [BYTE_W-1:0]    LINE_END_RESET = 8'h0A;
    localparam logic [BYTE_W-1:0]    CHAR_CR        = 8'h0D;

    // Register indexes (word address bit 2)
    localparam logic REG_TIMEOUT  = 1'b0;
    localparam logic REG_LINE_END = 1'b1;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_PING  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    // Message codes
    typedef enum logic [TX_W-1:0] {
        TX_NONE  = 2'd0,
        TX_READY = 2'd1,
        TX_PING  = 2'd2,
        TX_RESET = 2'd3
    } tx_msg_t;

    // Event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_UNMATCHED = 3'd1,
        EV_LINK_OK   = 3'd2,
        EV_PONG      = 3'd3,
        EV_RESP      = 3'd4,
        EV_ECHO      = 3'd5,
        EV_RETRY     = 3'd6,
        EV_REFUSED   = 3'd7
    } event_t;

    // Handshake states
    typedef enum logic [STATE_W-1:0] {
        LS_INIT  = 2'd0,
        LS_HELLO = 2'd1,
        LS_CONN  = 2'd2
    } link_state_t;

    // Keywords: peer prefix then suffix; byte 0 of each entry is the rightmost
    localparam int KW_NUM     = 5;
    localparam int KW_MAX_LEN = 12;
    localparam int KW_POS_W   = 4;
    localparam int KW_READY   = 0;
    localparam int KW_ACK     = 1;
    localparam int KW_PONG    = 2;
    localparam int KW_RESP    = 3;
    localparam int KW_ECHO    = 4;

    localparam logic [KW_MAX_LEN*BYTE_W-1:0] KW_TEXT [KW_NUM] = '{
        96'h00_59_44_41_45_52_5F_32_33_50_53_45,
        96'h00_00_00_4B_43_41_5F_32_33_50_53_45,
        96'h00_00_47_4E_4F_50_5F_32_33_50_53_45,
        96'h00_5F_50_53_45_52_5F_32_33_50_53_45,
        96'h20_3A_4F_48_43_45_5F_32_33_50_53_45
    };

    localparam logic [KW_POS_W-1:0] KW_LEN [KW_NUM] = '{
        4'd11, 4'd9, 4'd10, 4'd11, 4'd12
    };

endpackage

// ===== hdl/uart_line_handshake_fsm.sv =====
// Top level: line assembly, keyword matching and handshake state machine for a serial link.
//
// Usage
// - Input channel (s_valid/s_ready): one word per command: a received byte,
//   a one-millisecond tick, a ping request or a reset request.
// - Result channel (m_valid/m_ready): exactly one result word per command,
//   carrying the message to send, the event, the handshake state and link-up.
// - APB port: timeout_ticks at 0x0, line_end_char at 0x4; write only while idle.
// - The accepted word sits in the input register, is processed in a single
//   pass, then lands in the result register once that register is free.
// - Throughput: one word per cycle while the receiver takes every result;
//   the single pass from the input register to the result register sets that rate.
// - A stalled receiver holds the result register; one further word is still
//   taken into the input register, after which s_ready drops until m_ready.
// - Reset (aresetn low, synchronous) empties both registers, returns the
//   handshake to init, clears the line and idle count, and reloads the
//   configuration defaults (5000 ticks, line feed).
module uart_line_handshake_fsm (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ulh_pkg::CMD_W-1:0]     s_cmd,
    input  logic [ulh_pkg::BYTE_W-1:0]    s_rx_byte,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ulh_pkg::TX_W-1:0]      m_tx_msg,
    output logic [ulh_pkg::EV_W-1:0]      m_event_res,
    output logic [ulh_pkg::STATE_W-1:0]   m_link_state,
    output logic                          m_connected,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ulh_pkg::ADDR_W-1:0]    paddr,
    input  logic [ulh_pkg::DATA_W-1:0]    pwdata,
    output logic [ulh_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Configuration registers
    logic [ulh_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [ulh_pkg::BYTE_W-1:0]    line_end_reg;
    logic                          cfg_write;

    // Input register
    logic                          in_valid_reg;
    ulh_pkg::cmd_t                 in_cmd_reg;
    logic [ulh_pkg::BYTE_W-1:0]    in_byte_reg;

    // Handshake state
    ulh_pkg::link_state_t          proto_reg, proto_next;
    logic                          link_up_reg, link_up_next;
    logic [ulh_pkg::LEN_W-1:0]     line_len_reg, line_len_next;
    logic [ulh_pkg::KW_NUM-1:0]    match_reg, match_next;
    logic [ulh_pkg::IDLE_W-1:0]    idle_reg, idle_next;

    // Result register
    logic                          m_valid_reg;
    ulh_pkg::tx_msg_t              tx_reg, tx_next;
    ulh_pkg::event_t               ev_reg, ev_next;
    ulh_pkg::link_state_t          state_out_reg;
    logic                          conn_out_reg;

    // Datapath helpers
    logic                          advance;
    logic                          is_line_end;
    logic                          line_full;
    logic [ulh_pkg::KW_NUM-1:0]    kw_hit;
    logic [ulh_pkg::KW_NUM-1:0]    kw_miss;
    logic [ulh_pkg::IDLE_W-1:0]    idle_inc;
    logic                          timed_out;
    logic [ulh_pkg::KW_POS_W-1:0]  pos;

    // APB access: always ready, decode on word address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == ulh_pkg::REG_LINE_END) begin
            prdata = {{(ulh_pkg::DATA_W - ulh_pkg::BYTE_W){1'b0}}, line_end_reg};
        end else begin
            prdata = {{(ulh_pkg::DATA_W - ulh_pkg::TIMEOUT_W){1'b0}}, timeout_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= ulh_pkg::TIMEOUT_RESET;
            line_end_reg <= ulh_pkg::LINE_END_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == ulh_pkg::REG_LINE_END) begin
                line_end_reg <= pwdata[ulh_pkg::BYTE_W-1:0];
            end else begin
                timeout_reg <= pwdata[ulh_pkg::TIMEOUT_W-1:0];
            end
        end
    end

    // Handshake: advance the input word once the result register is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= ulh_pkg::cmd_t'(s_cmd);
            in_byte_reg <= s_rx_byte;
        end
    end

    // Line end, capacity and idle saturation
    assign is_line_end = (in_byte_reg == line_end_reg) || (in_byte_reg == ulh_pkg::CHAR_CR);
    assign line_full   = line_len_reg >= ulh_pkg::LEN_W'(ulh_pkg::LINE_CAP);
    assign idle_inc    = (idle_reg == ulh_pkg::IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign timed_out   = (proto_reg != ulh_pkg::LS_CONN) && (idle_inc > timeout_reg);
    assign pos         = line_len_reg[ulh_pkg::KW_POS_W-1:0];

    // Keyword compare at the current position, and full-keyword hits
    always_comb begin
        for (int k = 0; k < ulh_pkg::KW_NUM; k++) begin
            if (line_len_reg < {4'b0, ulh_pkg::KW_LEN[k]}) begin
                kw_miss[k] = in_byte_reg !=
                    ulh_pkg::KW_TEXT[k][pos*ulh_pkg::BYTE_W +: ulh_pkg::BYTE_W];
            end else begin
                kw_miss[k] = 1'b0;
            end
            kw_hit[k] = match_reg[k] && (line_len_reg >= {4'b0, ulh_pkg::KW_LEN[k]});
        end
    end

    // Next state
    always_comb begin
        proto_next    = proto_reg;
        link_up_next  = link_up_reg;
        line_len_next = line_len_reg;
        match_next    = match_reg;
        idle_next     = idle_reg;
        unique case (in_cmd_reg)
            ulh_pkg::CMD_BYTE: begin
                if (is_line_end) begin
                    line_len_next = '0;
                    match_next    = '1;
                    idle_next     = '0;
                    unique case (proto_reg)
                        ulh_pkg::LS_INIT: begin
                            if (kw_hit[ulh_pkg::KW_READY]) proto_next = ulh_pkg::LS_HELLO;
                        end
                        ulh_pkg::LS_HELLO: begin
                            if (kw_hit[ulh_pkg::KW_ACK]) begin
                                proto_next   = ulh_pkg::LS_CONN;
                                link_up_next = 1'b1;
                            end
                        end
                        ulh_pkg::LS_CONN: begin
                        end
                        default: begin
                            proto_next   = ulh_pkg::LS_INIT;
                            link_up_next = 1'b0;
                        end
                    endcase
                end else if (!line_full) begin
                    match_next    = match_reg & ~kw_miss;
                    line_len_next = line_len_reg + 1'b1;
                end
            end
            ulh_pkg::CMD_TICK: begin
                idle_next = idle_inc;
                if (timed_out || proto_reg == ulh_pkg::LS_INIT) begin
                    proto_next = ulh_pkg::LS_HELLO;
                    idle_next  = '0;
                end
            end
            ulh_pkg::CMD_PING: begin
            end
            ulh_pkg::CMD_RESET: begin
                proto_next    = ulh_pkg::LS_INIT;
                link_up_next  = 1'b0;
                line_len_next = '0;
                match_next    = '1;
                idle_next     = '0;
            end
            default: begin
            end
        endcase
    end

    // Result codes
    always_comb begin
        tx_next = ulh_pkg::TX_NONE;
        ev_next = ulh_pkg::EV_NONE;
        unique case (in_cmd_reg)
            ulh_pkg::CMD_BYTE: begin
                if (is_line_end) begin
                    ev_next = ulh_pkg::EV_UNMATCHED;
                    unique case (proto_reg)
                        ulh_pkg::LS_INIT: begin
                            if (kw_hit[ulh_pkg::KW_READY]) begin
                                tx_next = ulh_pkg::TX_READY;
                                ev_next = ulh_pkg::EV_NONE;
                            end
                        end
                        ulh_pkg::LS_HELLO: begin
                            priority if (kw_hit[ulh_pkg::KW_ACK]) begin
                                ev_next = ulh_pkg::EV_LINK_OK;
                            end else if (kw_hit[ulh_pkg::KW_READY]) begin
                                tx_next = ulh_pkg::TX_READY;
                                ev_next = ulh_pkg::EV_NONE;
                            end
                        end
                        ulh_pkg::LS_CONN: begin
                            priority if (kw_hit[ulh_pkg::KW_PONG]) begin
                                ev_next = ulh_pkg::EV_PONG;
                            end else if (kw_hit[ulh_pkg::KW_RESP]) begin
                                ev_next = ulh_pkg::EV_RESP;
                            end else if (kw_hit[ulh_pkg::KW_ECHO]) begin
                                ev_next = ulh_pkg::EV_ECHO;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ulh_pkg::CMD_TICK: begin
                priority if (timed_out) begin
                    tx_next = ulh_pkg::TX_READY;
                    ev_next = ulh_pkg::EV_RETRY;
                end else if (proto_reg == ulh_pkg::LS_INIT) begin
                    tx_next = ulh_pkg::TX_READY;
                end
            end
            ulh_pkg::CMD_PING: begin
                if (link_up_reg) begin
                    tx_next = ulh_pkg::TX_PING;
                end else begin
                    ev_next = ulh_pkg::EV_REFUSED;
                end
            end
            ulh_pkg::CMD_RESET: begin
                tx_next = ulh_pkg::TX_RESET;
            end
            default: begin
            end
        endcase
    end

    // State registers: update once per processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proto_reg    <= ulh_pkg::LS_INIT;
            link_up_reg  <= 1'b0;
            line_len_reg <= '0;
            match_reg    <= '1;
            idle_reg     <= '0;
        end else if (advance) begin
            proto_reg    <= proto_next;
            link_up_reg  <= link_up_next;
            line_len_reg <= line_len_next;
            match_reg    <= match_next;
            idle_reg     <= idle_next;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tx_reg        <= tx_next;
            ev_reg        <= ev_next;
            state_out_reg <= proto_next;
            conn_out_reg  <= link_up_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_tx_msg     = tx_reg;
    assign m_event_res  = ev_reg;
    assign m_link_state = state_out_reg;
    assign m_connected  = conn_out_reg;

    // Link-up flag tracks the connected state
    a_link_up_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        link_up_reg == (proto_reg == ulh_pkg::LS_CONN))
        else $error("link-up flag disagrees with handshake state");

    // An empty line keeps every keyword candidate
    a_empty_line_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_len_reg == '0) |-> (match_reg == '1))
        else $error("match bits not all set on an empty line");

    // A READY sent on a tick restarts the idle count
    a_tick_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == ulh_pkg::CMD_TICK && tx_next == ulh_pkg::TX_READY)
        |=> (idle_reg == '0))
        else $error("idle count not cleared after a tick retry");

    // The connected state never retries the handshake
    a_no_retry_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && proto_reg == ulh_pkg::LS_CONN) |-> (ev_next != ulh_pkg::EV_RETRY))
        else $error("timeout retry raised while connected");

endmodule
